>>> rtl/tns_pkg.sv
// shared types and constants for the tag name substitution block
package tns_pkg;

   localparam int PATTERN_MAX_DEF = 16;
   localparam int REPLACE_MAX_DEF = 16;

   localparam int BYTE_W    = 8;
   localparam int REG_W     = 64;
   localparam int LEN_W     = 5;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAT_LO  = 3'd0,
      CSR_PAT_HI  = 3'd1,
      CSR_PAT_LEN = 3'd2,
      CSR_REP_LO  = 3'd3,
      CSR_REP_HI  = 3'd4,
      CSR_REP_LEN = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [REG_W-1:0] pat_lo;
      logic [REG_W-1:0] pat_hi;
      logic [LEN_W-1:0] pat_len;
      logic [REG_W-1:0] rep_lo;
      logic [REG_W-1:0] rep_hi;
      logic [LEN_W-1:0] rep_len;
   } cfg_type;

   typedef struct packed {
      logic              line_end;
      logic [BYTE_W-1:0] text_byte;
   } in_item_type;

   typedef struct packed {
      logic              run_last;
      logic [BYTE_W-1:0] out_byte;
   } out_item_type;

   typedef enum logic [1:0] {
      ST_RUN   = 2'd0,
      ST_REPL  = 2'd1,
      ST_DRAIN = 2'd2
   } eng_state_type;

endpackage

>>> rtl/tns_pipe_reg.sv
// one-deep valid/ready pipeline register
module tns_pipe_reg #(
   parameter int WIDTH = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff;
   logic             valid_in;
   logic [WIDTH-1:0] data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

endmodule

>>> rtl/tns_csr.sv
// configuration registers of the tag name substitution block
module tns_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tns_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tns_pkg::REG_W-1:0]      csr_data,
   output tns_pkg::cfg_type               cfg,
   output logic                           win_clear
);

   tns_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;
   // a new pattern length drops the pending window
   assign win_clear = csr_valid && (csr_index == tns_pkg::CSR_PAT_LEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pat_lo  <= '0;
         cfg_ff.pat_hi  <= '0;
         cfg_ff.pat_len <= tns_pkg::LEN_W'(1);
         cfg_ff.rep_lo  <= '0;
         cfg_ff.rep_hi  <= '0;
         cfg_ff.rep_len <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            tns_pkg::CSR_PAT_LO:  cfg_ff.pat_lo  <= csr_data;
            tns_pkg::CSR_PAT_HI:  cfg_ff.pat_hi  <= csr_data;
            tns_pkg::CSR_PAT_LEN: cfg_ff.pat_len <= csr_data[tns_pkg::LEN_W-1:0];
            tns_pkg::CSR_REP_LO:  cfg_ff.rep_lo  <= csr_data;
            tns_pkg::CSR_REP_HI:  cfg_ff.rep_hi  <= csr_data;
            tns_pkg::CSR_REP_LEN: cfg_ff.rep_len <= csr_data[tns_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

>>> rtl/tns_engine.sv
// lookahead window, bracket tracking, match and replacement sequencing
module tns_engine #(
   parameter int PATTERN_MAX = tns_pkg::PATTERN_MAX_DEF,
   parameter int REPLACE_MAX = tns_pkg::REPLACE_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic                  item_valid,
   input  tns_pkg::in_item_type  item,
   output logic                  consume,
   input  tns_pkg::cfg_type      cfg,
   input  logic                  win_clear,
   output logic                  beat_valid,
   output tns_pkg::out_item_type beat
);

   localparam int PL_W = $clog2(PATTERN_MAX + 1);
   localparam int RL_W = $clog2(REPLACE_MAX + 1);
   localparam int KW   = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;
   localparam int REG_BYTES = 2 * tns_pkg::REG_W / tns_pkg::BYTE_W;

   localparam logic [7:0] CH_OPEN    = 8'h3C;
   localparam logic [7:0] CH_CLOSE   = 8'h3E;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   function automatic logic [7:0] lower_ascii(input logic [7:0] c);
      lower_ascii = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'h20) : c;
   endfunction

   tns_pkg::eng_state_type state_ff, state_in;
   logic [7:0]      win_ff [PATTERN_MAX];
   logic [7:0]      win_in [PATTERN_MAX];
   logic [7:0]      wv     [PATTERN_MAX];
   logic [PL_W-1:0] cnt_ff, cnt_in, wcnt;
   logic            inside_ff, inside_in;
   logic [RL_W-1:0] k_ff, k_in;
   logic            ret_ff, ret_in;

   logic [2*tns_pkg::REG_W-1:0] pat_all, rep_all;
   logic [7:0]      pat_b [PATTERN_MAX];
   logic [7:0]      rep_b [REPLACE_MAX];
   logic [PL_W-1:0] plen;
   logic [RL_W-1:0] rlen;
   logic            acc, drain_mode, decide, is_br, match, do_match, long_repl;
   logic [7:0]      head;

   assign pat_all = {cfg.pat_hi, cfg.pat_lo};
   assign rep_all = {cfg.rep_hi, cfg.rep_lo};

   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         pat_b[j] = (j < REG_BYTES) ? pat_all[8*(j % REG_BYTES) +: 8] : 8'h00;
      end
      for (int j = 0; j < REPLACE_MAX; j++) begin
         rep_b[j] = (j < REG_BYTES) ? rep_all[8*(j % REG_BYTES) +: 8] : 8'h00;
      end
   end

   // effective lengths: zero pattern counts as one, both saturate
   always_comb begin
      if (cfg.pat_len == '0) begin
         plen = PL_W'(1);
      end else if (int'(cfg.pat_len) > PATTERN_MAX) begin
         plen = PL_W'(PATTERN_MAX);
      end else begin
         plen = PL_W'(cfg.pat_len);
      end
      if (int'(cfg.rep_len) > REPLACE_MAX) begin
         rlen = RL_W'(REPLACE_MAX);
      end else begin
         rlen = RL_W'(cfg.rep_len);
      end
   end

   assign consume = (state_ff == tns_pkg::ST_RUN) && go;
   assign acc     = consume && item_valid;

   // working window: stored bytes with the incoming byte appended
   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         wv[j] = (acc && cnt_ff == PL_W'(j)) ? item.text_byte : win_ff[j];
      end
      wcnt = cnt_ff + PL_W'(acc && (cnt_ff < PL_W'(PATTERN_MAX)));
   end

   assign head       = wv[0];
   assign is_br      = (head == CH_OPEN) || (head == CH_CLOSE);
   assign drain_mode = (state_ff == tns_pkg::ST_DRAIN) || (acc && item.line_end);
   assign decide     = (state_ff != tns_pkg::ST_REPL) &&
                       (drain_mode ? (wcnt != '0) : (acc && wcnt >= plen));

   always_comb begin
      match = 1'b1;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         if (PL_W'(j) < plen && lower_ascii(wv[j]) != lower_ascii(pat_b[j])) begin
            match = 1'b0;
         end
      end
   end

   assign do_match  = !is_br && inside_ff && (wcnt >= plen) && match;
   assign long_repl = decide && do_match && (rlen > RL_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      if (go) begin
         case (state_ff)
            tns_pkg::ST_RUN: begin
               if (long_repl) begin
                  state_in = tns_pkg::ST_REPL;
               end else if (acc && item.line_end) begin
                  state_in = tns_pkg::ST_DRAIN;
               end
            end
            tns_pkg::ST_REPL: begin
               if (k_ff + RL_W'(1) == rlen) begin
                  state_in = ret_ff ? tns_pkg::ST_DRAIN : tns_pkg::ST_RUN;
               end
            end
            tns_pkg::ST_DRAIN: begin
               if (long_repl) begin
                  state_in = tns_pkg::ST_REPL;
               end else if (wcnt == '0) begin
                  state_in = tns_pkg::ST_RUN;
               end
            end
            default: state_in = tns_pkg::ST_RUN;
         endcase
      end
   end

   // beats and window update
   always_comb begin
      beat_valid    = 1'b0;
      beat.out_byte = head;
      beat.run_last = 1'b0;
      win_in        = win_ff;
      cnt_in        = cnt_ff;
      inside_in     = inside_ff;
      k_in          = k_ff;
      ret_in        = ret_ff;
      if (go) begin
         win_in = wv;
         cnt_in = wcnt;
         if (state_ff == tns_pkg::ST_REPL) begin
            beat_valid    = 1'b1;
            beat.out_byte = rep_b[k_ff[KW-1:0]];
            beat.run_last = (k_ff + RL_W'(1) == rlen) && !ret_ff;
            k_in          = k_ff + RL_W'(1);
         end else if (decide) begin
            if (do_match) begin
               cnt_in = '0;
               k_in   = RL_W'(1);
               ret_in = drain_mode;
               if (rlen != '0) begin
                  beat_valid    = 1'b1;
                  beat.out_byte = rep_b[0];
                  beat.run_last = !drain_mode && (rlen == RL_W'(1));
               end
            end else begin
               beat_valid    = 1'b1;
               beat.out_byte = head;
               beat.run_last = !drain_mode;
               for (int j = 0; j < PATTERN_MAX - 1; j++) begin
                  win_in[j] = wv[j+1];
               end
               cnt_in = wcnt - PL_W'(1);
               if (is_br) begin
                  inside_in = (head == CH_OPEN);
               end
            end
         end else if (state_ff == tns_pkg::ST_DRAIN) begin
            // window empty: close the line
            beat_valid    = 1'b1;
            beat.out_byte = CH_NEWLINE;
            beat.run_last = 1'b1;
            inside_in     = 1'b0;
         end
      end
      if (win_clear) begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tns_pkg::ST_RUN;
         cnt_ff    <= '0;
         inside_ff <= 1'b0;
         k_ff      <= '0;
         ret_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         inside_ff <= inside_in;
         k_ff      <= k_in;
         ret_ff    <= ret_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

>>> rtl/tag_name_substitution.sv
// top level of the tag name substitution block
// datapath: input register, engine with lookahead window, result register
// throughput: one byte per cycle while the result stream is ready; a match emits one replacement
//   byte per cycle, and the input is held while its replacement bytes go out
// end of line: window drained one head byte per cycle while the result stream is ready, matches
//   still replaced, then a newline beat; reset: synchronous, clears control state and loads register defaults
module tag_name_substitution #(
   parameter int PATTERN_MAX = tns_pkg::PATTERN_MAX_DEF,
   parameter int REPLACE_MAX = tns_pkg::REPLACE_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // input stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // text_byte
   input  logic                          req_tlast,   // line_end
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // out_byte
   output logic                          rsp_tlast,   // run_last
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tns_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tns_pkg::REG_W-1:0]     csr_data
);

   tns_pkg::in_item_type  req_item, eng_item;
   tns_pkg::out_item_type eng_beat, rsp_item;
   tns_pkg::cfg_type      cfg;
   logic                  win_clear;
   logic                  eng_item_valid, eng_consume;
   logic                  eng_beat_valid, out_space;

   assign req_item.text_byte = req_tdata;
   assign req_item.line_end  = req_tlast;

   // input register: one beat held for the engine
   tns_pipe_reg #(
      .WIDTH ($bits(tns_pkg::in_item_type))
   ) u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_item),
      .out_valid (eng_item_valid),
      .out_ready (eng_consume),
      .out_data  (eng_item)
   );

   // register file, pattern length write empties the window
   tns_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .win_clear (win_clear)
   );

   // engine steps whenever the result register can take a beat
   tns_engine #(
      .PATTERN_MAX (PATTERN_MAX),
      .REPLACE_MAX (REPLACE_MAX)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .go         (out_space),
      .item_valid (eng_item_valid),
      .item       (eng_item),
      .consume    (eng_consume),
      .cfg        (cfg),
      .win_clear  (win_clear),
      .beat_valid (eng_beat_valid),
      .beat       (eng_beat)
   );

   // result register
   tns_pipe_reg #(
      .WIDTH ($bits(tns_pkg::out_item_type))
   ) u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (eng_beat_valid),
      .in_ready  (out_space),
      .in_data   (eng_beat),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_item)
   );

   assign rsp_tdata = rsp_item.out_byte;
   assign rsp_tlast = rsp_item.run_last;

endmodule
